>>> src/ldr_pkg.sv
// types, constants and codes shared by the lan designated router election block
// no dependencies; used by ldr_ram users and lan_designated_router_election
package ldr_pkg;

  // default depth of the adjacency table
  localparam int unsigned AdjSlotsDef = 16;

  // field widths fixed by the item format
  localparam int unsigned OpW       = 2;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned PrioW     = 7;
  localparam int unsigned MacW      = 48;
  localparam int unsigned LanIdW    = 56;
  localparam int unsigned CircuitW  = 8;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 48;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_WRITE   = 2'd0,
    OP_ELECT   = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  // election outcome codes
  typedef enum logic [1:0] {
    OUT_NONE    = 2'd0,
    OUT_RESIGN  = 2'd1,
    OUT_ADOPT   = 2'd2,
    OUT_BECOME  = 2'd3
  } outcome_e;

  // adjacency state and kind codes
  localparam logic [1:0] AdjStateUp = 2'd2;
  localparam logic [1:0] KindL1Is   = 2'd0;
  localparam logic [1:0] KindL2Is   = 2'd1;
  localparam logic [1:0] KindEs     = 2'd2;

  // election level codes
  localparam logic [1:0] Level1 = 2'd1;
  localparam logic [1:0] Level2 = 2'd2;

  // configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_L1_PRIO  = 3'd0,
    CFG_L2_PRIO  = 3'd1,
    CFG_OWN_MAC  = 3'd2,
    CFG_SYS_ID   = 3'd3,
    CFG_LOCAL_CN = 3'd4
  } cfg_idx_e;

  // input item
  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [SlotW-1:0]  slot;
    logic [1:0]        adj_state;
    logic [1:0]        adj_kind;
    logic              auto_config;
    logic [PrioW-1:0]  neighbor_priority;
    logic [MacW-1:0]   neighbor_mac;
    logic [LanIdW-1:0] neighbor_lan_id;
    logic [1:0]        level;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [1:0]        outcome;
    logic              is_designated;
    logic [LanIdW-1:0] lan_id;
    logic              winner_found;
    logic [SlotW-1:0]  winner_slot;
  } res_item_t;

  // one adjacency table entry as held in memory
  typedef struct packed {
    logic [LanIdW-1:0] lan_id;
    logic [MacW-1:0]   mac;
    logic [PrioW-1:0]  prio;
    logic              auto_config;
    logic [1:0]        kind;
    logic [1:0]        state;
  } adj_entry_t;

  localparam int unsigned EntryW = $bits(adj_entry_t);

endpackage

>>> src/ldr_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module ldr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/lan_designated_router_election.sv
// designated system election over a table of lan adjacencies, top level
// depends on ldr_pkg and ldr_ram
//
// An item is taken when start is high and busy is low. A write of an adjacency entry and
// the release of the hold-down give the result strobe done_o in the next cycle, and busy
// stays low, so items of that kind may follow back to back. An election holds busy high
// until it has decided: the table is walked one entry per cycle through the single read
// port of its memory, then state ST_LAST finishes the last compare and ST_DECIDE decides
// the outcome. A result appears on result_o in the cycle in which done_o is high and is
// held there until the next result; the receiver must take it then. The configuration
// port is always ready and should be written only while the block is idle.
module lan_designated_router_election #(
  parameter int unsigned ADJ_SLOTS = ldr_pkg::AdjSlotsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // item channel
  input  logic                               start,
  output logic                               busy,
  input  ldr_pkg::in_item_t                  item_i,
  // result channel
  output logic                               done_o,
  output ldr_pkg::res_item_t                 result_o,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ldr_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [ldr_pkg::CfgDataW-1:0]       cfg_data_i
);

  import ldr_pkg::*;

  localparam int unsigned AddrW = $clog2(ADJ_SLOTS);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(ADJ_SLOTS - 1);

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_LAST   = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [PrioW-1:0]    l1_prio_q, l2_prio_q;
  logic [MacW-1:0]     own_mac_q, sys_id_q;
  logic [CircuitW-1:0] local_cn_q;

  // election state
  logic [1:0]        des_q, des_d;
  logic [LanIdW-1:0] lan_q [2];
  logic [LanIdW-1:0] lan_d [2];
  logic              hold_q, hold_d;
  logic              done_q, done_d;

  // scan control
  logic [AddrW-1:0]  cnt_q, cnt_d;
  logic              rd_pend_q, rd_pend_d;
  logic [AddrW-1:0]  rd_idx_q, rd_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic              li_q, li_d;
  logic [1:0]        want_kind_q, want_kind_d;
  logic              found_q, found_d;
  logic              any_up_q, any_up_d;

  // scan payload
  logic [PrioW-1:0]  best_prio_q, best_prio_d;
  logic [MacW-1:0]   best_mac_q, best_mac_d;
  logic [SlotW-1:0]  wslot_q, wslot_d;
  logic [LanIdW-1:0] win_lan_q, win_lan_d;
  res_item_t         res_q, res_d;

  // adjacency table
  logic [ADJ_SLOTS-1:0] vld_q, vld_d;
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  adj_entry_t           ram_wentry;
  logic [EntryW-1:0]    ram_rdata;
  adj_entry_t           rd_entry;

  logic accept;
  logic in_li;
  logic slot_ok;
  logic e_up;
  logic e_beats;
  logic [LanIdW-1:0] self_id;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign in_li       = (item_i.level == Level2);
  assign slot_ok     = (32'(item_i.slot) < ADJ_SLOTS);
  assign self_id     = {sys_id_q, local_cn_q};

  // table write on an accepted entry write
  assign ram_we    = accept && (item_i.op == OP_WRITE) && slot_ok;
  assign ram_waddr = AddrW'(item_i.slot);
  assign ram_wentry = '{
    lan_id:      item_i.neighbor_lan_id,
    mac:         item_i.neighbor_mac,
    prio:        item_i.neighbor_priority,
    auto_config: item_i.auto_config,
    kind:        item_i.adj_kind,
    state:       item_i.adj_state
  };

  ldr_ram #(
    .Width (EntryW),
    .Depth (ADJ_SLOTS)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  // compare of the entry read back against the best so far
  assign rd_entry = adj_entry_t'(ram_rdata);
  assign e_up     = rd_pend_q && rd_vld_q && (rd_entry.state == AdjStateUp);
  assign e_beats  = e_up && (rd_entry.kind == want_kind_q) &&
                    ({rd_entry.prio, rd_entry.mac} > {best_prio_q, best_mac_q});

  // sequencer and next state
  always_comb begin
    state_d     = state_q;
    des_d       = des_q;
    lan_d       = lan_q;
    hold_d      = hold_q;
    done_d      = 1'b0;
    cnt_d       = cnt_q;
    rd_pend_d   = 1'b0;
    rd_idx_d    = cnt_q;
    rd_vld_d    = vld_q[cnt_q];
    li_d        = li_q;
    want_kind_d = want_kind_q;
    found_d     = found_q;
    any_up_d    = any_up_q;
    best_prio_d = best_prio_q;
    best_mac_d  = best_mac_q;
    wslot_d     = wslot_q;
    win_lan_d   = win_lan_q;
    res_d       = res_q;
    vld_d       = vld_q;

    // fold in the entry read in the previous cycle
    if (e_beats) begin
      found_d     = 1'b1;
      wslot_d     = SlotW'(rd_idx_q);
      best_prio_d = rd_entry.prio;
      best_mac_d  = rd_entry.mac;
      win_lan_d   = rd_entry.lan_id;
    end
    if (e_up && ((rd_entry.kind == KindL1Is) || (rd_entry.kind == KindL2Is) ||
                 ((rd_entry.kind == KindEs) && rd_entry.auto_config))) begin
      any_up_d = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (ram_we) begin
            vld_d[ram_waddr] = 1'b1;
          end
          if ((item_i.op == OP_ELECT) && !hold_q &&
              ((item_i.level == Level1) || (item_i.level == Level2))) begin
            state_d     = ST_SCAN;
            cnt_d       = '0;
            li_d        = in_li;
            want_kind_d = in_li ? KindL2Is : KindL1Is;
            found_d     = 1'b0;
            any_up_d    = 1'b0;
            wslot_d     = '0;
            best_prio_d = in_li ? l2_prio_q : l1_prio_q;
            best_mac_d  = own_mac_q;
          end else begin
            if (item_i.op == OP_RELEASE) begin
              hold_d = 1'b0;
            end
            done_d              = 1'b1;
            res_d.outcome       = OUT_NONE;
            res_d.is_designated = des_q[in_li];
            res_d.lan_id        = lan_q[in_li];
            res_d.winner_found  = 1'b0;
            res_d.winner_slot   = '0;
          end
        end
      end
      ST_SCAN: begin
        rd_pend_d = 1'b1;
        if (cnt_q == LastAddr) begin
          state_d = ST_LAST;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_LAST: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d       = ST_IDLE;
        res_d.outcome = OUT_NONE;
        if (found_q) begin
          if (des_q[li_q]) begin
            lan_d[li_q]   = win_lan_q;
            des_d[li_q]   = 1'b0;
            res_d.outcome = OUT_RESIGN;
          end else if (win_lan_q != lan_q[li_q]) begin
            lan_d[li_q]   = win_lan_q;
            res_d.outcome = OUT_ADOPT;
          end
        end else if (!des_q[li_q] && any_up_q) begin
          des_d[li_q]   = 1'b1;
          lan_d[li_q]   = self_id;
          res_d.outcome = OUT_BECOME;
        end
        done_d              = 1'b1;
        res_d.is_designated = des_d[li_q];
        res_d.lan_id        = lan_d[li_q];
        res_d.winner_found  = found_q;
        res_d.winner_slot   = wslot_q;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      des_q       <= '0;
      lan_q[0]    <= '0;
      lan_q[1]    <= '0;
      hold_q      <= 1'b1;
      done_q      <= 1'b0;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      li_q        <= 1'b0;
      want_kind_q <= KindL1Is;
      found_q     <= 1'b0;
      any_up_q    <= 1'b0;
      vld_q       <= '0;
    end else begin
      state_q     <= state_d;
      des_q       <= des_d;
      lan_q       <= lan_d;
      hold_q      <= hold_d;
      done_q      <= done_d;
      cnt_q       <= cnt_d;
      rd_pend_q   <= rd_pend_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= rd_vld_d;
      li_q        <= li_d;
      want_kind_q <= want_kind_d;
      found_q     <= found_d;
      any_up_q    <= any_up_d;
      vld_q       <= vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    best_prio_q <= best_prio_d;
    best_mac_q  <= best_mac_d;
    wslot_q     <= wslot_d;
    win_lan_q   <= win_lan_d;
    res_q       <= res_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_prio_q  <= PrioW'(64);
      l2_prio_q  <= PrioW'(64);
      own_mac_q  <= '0;
      sys_id_q   <= '0;
      local_cn_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_L1_PRIO:  l1_prio_q  <= cfg_data_i[PrioW-1:0];
        CFG_L2_PRIO:  l2_prio_q  <= cfg_data_i[PrioW-1:0];
        CFG_OWN_MAC:  own_mac_q  <= cfg_data_i[MacW-1:0];
        CFG_SYS_ID:   sys_id_q   <= cfg_data_i[MacW-1:0];
        CFG_LOCAL_CN: local_cn_q <= cfg_data_i[CircuitW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
